/* rtl/core/gpio_port_with_edge_interrupts_top_macros.svh */
// Assertion macros shared by the GPIO port checker.
`ifndef GPIO_PORT_WITH_EDGE_INTERRUPTS_TOP_MACROS_SVH
`define GPIO_PORT_WITH_EDGE_INTERRUPTS_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GPIOEI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gpio port check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GPIOEI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gpio port check failed");

`endif

/* rtl/core/gpioei_pkg.sv */
package gpioei_pkg;

    // Transfer kinds carried on the input tuser.
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    // Register map.
    localparam logic [3:0] REG_CFGLO = 4'd0;
    localparam logic [3:0] REG_CFGHI = 4'd1;
    localparam logic [3:0] REG_IN    = 4'd2;
    localparam logic [3:0] REG_OUT   = 4'd3;
    localparam logic [3:0] REG_BSRR  = 4'd4;
    localparam logic [3:0] REG_BRR   = 4'd5;
    localparam logic [3:0] REG_MASK  = 4'd6;
    localparam logic [3:0] REG_RISE  = 4'd7;
    localparam logic [3:0] REG_FALL  = 4'd8;
    localparam logic [3:0] REG_PEND  = 4'd9;
    localparam logic [3:0] REG_LAST  = REG_PEND;

    localparam int unsigned NUM_PINS = 16;

    // Pin field encoding: bits 1:0 mode, bits 3:2 configuration.
    localparam logic [31:0] CFG_RESET  = 32'h4444_4444;
    localparam logic [1:0]  MODE_INPUT = 2'b00;
    localparam logic [1:0]  CNF_PULL   = 2'b10;

    // One decoded request.
    typedef struct packed {
        cmd_t        command;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pad_levels;
    } req_t;

    // Register contents that feed the pin outputs.
    typedef struct packed {
        logic [31:0] cfg_lo;
        logic [31:0] cfg_hi;
        logic [15:0] latch;
        logic [15:0] irq;
    } view_t;

    // Pin control masks.
    typedef struct packed {
        logic [15:0] drive;
        logic [15:0] pull_up;
        logic [15:0] pull_down;
    } pins_t;

endpackage

/* rtl/core/gpioei_pindec.sv */
module gpioei_pindec
    import gpioei_pkg::*;
(
    input  view_t view,
    output pins_t pins
);

    logic [63:0] fields;

    assign fields = {view.cfg_hi, view.cfg_lo};

    // Each pin is decoded on its own from its 4-bit field.
    always_comb begin
        pins = '0;
        for (int i = 0; i < NUM_PINS; i++) begin
            if (fields[4*i +: 2] != MODE_INPUT) begin
                pins.drive[i] = 1'b1;
            end else if (fields[4*i+2 +: 2] == CNF_PULL) begin
                pins.pull_up[i]   = view.latch[i];
                pins.pull_down[i] = ~view.latch[i];
            end
        end
    end

endmodule

/* rtl/core/gpioei_regs.sv */
module gpioei_regs
    import gpioei_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  req_t        req,
    output logic [31:0] read_data,
    output logic        bad_access,
    output view_t       view_next
);

    logic [31:0] cfg_lo_reg, cfg_lo_next;
    logic [31:0] cfg_hi_reg, cfg_hi_next;
    logic [15:0] sample_reg, sample_next;
    logic [15:0] latch_reg, latch_next;
    logic [15:0] mask_reg, mask_next;
    logic [15:0] rise_reg, rise_next;
    logic [15:0] fall_reg, fall_next;
    logic [15:0] pend_reg, pend_next;
    logic [15:0] wr_lo;
    logic [15:0] wr_hi;

    assign wr_lo = req.write_data[15:0];
    assign wr_hi = req.write_data[31:16];

    // Bus decode and pad sampling for one request.
    always_comb begin
        cfg_lo_next = cfg_lo_reg;
        cfg_hi_next = cfg_hi_reg;
        sample_next = sample_reg;
        latch_next  = latch_reg;
        mask_next   = mask_reg;
        rise_next   = rise_reg;
        fall_next   = fall_reg;
        pend_next   = pend_reg;
        read_data   = '0;
        bad_access  = 1'b0;
        case (req.command)
            CMD_READ: begin
                if (req.reg_index > REG_LAST) begin
                    bad_access = 1'b1;
                end else begin
                    unique case (req.reg_index)
                        REG_CFGLO: read_data = cfg_lo_reg;
                        REG_CFGHI: read_data = cfg_hi_reg;
                        REG_IN:    read_data = {16'h0000, sample_reg};
                        REG_OUT:   read_data = {16'h0000, latch_reg};
                        REG_MASK:  read_data = {16'h0000, mask_reg};
                        REG_RISE:  read_data = {16'h0000, rise_reg};
                        REG_FALL:  read_data = {16'h0000, fall_reg};
                        REG_PEND:  read_data = {16'h0000, pend_reg};
                        default:   read_data = '0;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (req.reg_index > REG_LAST) begin
                    bad_access = 1'b1;
                end else begin
                    unique case (req.reg_index)
                        REG_CFGLO: cfg_lo_next = req.write_data;
                        REG_CFGHI: cfg_hi_next = req.write_data;
                        REG_OUT:   latch_next  = wr_lo;
                        // Set bits win over clear bits on the same pin.
                        REG_BSRR:  latch_next  = (latch_reg & ~wr_hi) | wr_lo;
                        REG_BRR:   latch_next  = latch_reg & ~wr_lo;
                        REG_MASK:  mask_next   = wr_lo;
                        REG_RISE:  rise_next   = wr_lo;
                        REG_FALL:  fall_next   = wr_lo;
                        REG_PEND:  pend_next   = pend_reg & ~wr_lo;
                        default:   ;
                    endcase
                end
            end
            CMD_TICK: begin
                sample_next = req.pad_levels;
                pend_next   = pend_reg
                            | (~sample_reg & req.pad_levels & rise_reg)
                            | (sample_reg & ~req.pad_levels & fall_reg);
            end
            default: ;
        endcase
    end

    // State as it stands after this request.
    assign view_next.cfg_lo = cfg_lo_next;
    assign view_next.cfg_hi = cfg_hi_next;
    assign view_next.latch  = latch_next;
    assign view_next.irq    = pend_next & mask_next;

    // Register file, updated once per processed transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_lo_reg <= CFG_RESET;
            cfg_hi_reg <= CFG_RESET;
            sample_reg <= '0;
            latch_reg  <= '0;
            mask_reg   <= '0;
            rise_reg   <= '0;
            fall_reg   <= '0;
            pend_reg   <= '0;
        end else if (step_en) begin
            cfg_lo_reg <= cfg_lo_next;
            cfg_hi_reg <= cfg_hi_next;
            sample_reg <= sample_next;
            latch_reg  <= latch_next;
            mask_reg   <= mask_next;
            rise_reg   <= rise_next;
            fall_reg   <= fall_next;
            pend_reg   <= pend_next;
        end
    end

endmodule

/* rtl/core/gpio_port_with_edge_interrupts_top.sv */
// GPIO port with edge interrupts, 16 pins.
// Input channel: one transfer per request. s_tuser carries the command
// (0 bus read, 1 bus write, 2 pad sample tick, 3 no operation); s_tdata
// carries the register index, the write word and the sampled pad levels.
// Output channel: exactly one transfer per request, in order. m_tdata holds
// the read word and the pad output, drive enable, pull-up, pull-down and
// masked interrupt masks as they stand after the request; m_tuser flags a
// bus access to an index above nine.
// Path: a request waits in the input register until the result register is
// free or being drained, and its result is then offered from the result
// register; a stall on m_tready can hold it in between.
// Throughput: one request per cycle while m_tready stays high; the register
// file is read, decoded and updated between the two registers.
// Reset: pin fields return to floating input (0x44444444 per word), all
// other registers clear, and both channels come up empty.
// Stall: when m_tready is low the result register holds its transfer; the
// input register still takes one more request, and s_tready drops only
// once both registers are full.
module gpio_port_with_edge_interrupts_top
    import gpioei_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // s_tdata, low to high: reg_index[3:0], write_data[35:4],
    // pad_levels[51:36], zero fill[55:52].
    input  logic [55:0]  s_tdata,
    // s_tuser: command[1:0].
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // m_tdata, low to high: read_data[31:0], pad_out[47:32],
    // pad_drive_enable[63:48], pull_up_mask[79:64], pull_down_mask[95:80],
    // irq_lines[111:96].
    output logic [111:0] m_tdata,
    // m_tuser: bad_access[0].
    output logic         m_tuser
);

    logic         in_valid_reg;
    req_t         req_reg;
    logic         out_valid_reg;
    logic [111:0] out_data_reg;
    logic         out_bad_reg;
    logic         advance;
    logic [31:0]  read_data;
    logic         bad_access;
    view_t        view_next;
    pins_t        pins;

    // A request moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg.command    <= cmd_t'(s_tuser);
            req_reg.reg_index  <= s_tdata[3:0];
            req_reg.write_data <= s_tdata[35:4];
            req_reg.pad_levels <= s_tdata[51:36];
        end
    end

    gpioei_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .req        (req_reg),
        .read_data  (read_data),
        .bad_access (bad_access),
        .view_next  (view_next)
    );

    gpioei_pindec u_pindec (
        .view (view_next),
        .pins (pins)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {view_next.irq, pins.pull_down, pins.pull_up,
                             pins.drive, view_next.latch, read_data};
            out_bad_reg  <= bad_access;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_bad_reg;

endmodule

/* rtl/core/gpioei_checker.sv */
`include "gpio_port_with_edge_interrupts_top_macros.svh"

module gpioei_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tuser
);

    logic [15:0] pad_out;
    logic [15:0] drive;
    logic [15:0] pull_up;
    logic [15:0] pull_down;

    // Pin masks as packed on the result channel.
    assign pad_out   = m_tdata[47:32];
    assign drive     = m_tdata[63:48];
    assign pull_up   = m_tdata[79:64];
    assign pull_down = m_tdata[95:80];

    // A stalled result transfer keeps its payload.
    `GPIOEI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

    // With no result waiting the input side is always ready.
    `GPIOEI_ASSERT_SAME(a_ready_when_empty, !m_tvalid, s_tready)

    // A rejected bus access never returns read data.
    `GPIOEI_ASSERT_SAME(a_bad_no_data, m_tvalid && m_tuser, m_tdata[31:0] == 32'h0)

    // Driven pins never carry a pull.
    `GPIOEI_ASSERT_SAME(a_drive_no_pull, m_tvalid, (drive & (pull_up | pull_down)) == 16'h0)

    // Pull-up follows a latch bit of one, pull-down a latch bit of zero.
    `GPIOEI_ASSERT_SAME(a_pull_dir, m_tvalid, ((pull_up & ~pad_out) | (pull_down & pad_out)) == 16'h0)

endmodule

bind gpio_port_with_edge_interrupts_top gpioei_checker u_gpioei_checker (.*);
